@@ src/csr_pkg.sv @@
`default_nettype none
package csr_pkg;
   localparam int DefMaxRows    = 1024;
   localparam int DefMaxColumns = 1024;
   localparam int DefMaxEntries = 4096;
   localparam int DefValueBits  = 64;

   localparam int FuncBits   = 1;
   localparam int IndexBits  = 10;
   localparam int OutValBits = 64;
   localparam int SlotBits   = 12;
   localparam int StatusBits = 2;
   localparam int CsrAddrBits = 2;
   localparam int CsrDataBits = 64;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_ORDER    = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [CsrAddrBits-1:0] {
      REG_ROW_COUNT   = 2'd0,
      REG_COL_COUNT   = 2'd1,
      REG_CAPACITY    = 2'd2,
      REG_ABSENT      = 2'd3
   } reg_index_type;

   localparam logic [FuncBits-1:0] FUNC_GET = 1'b0;
   localparam logic [FuncBits-1:0] FUNC_SET = 1'b1;
endpackage
`default_nettype wire

@@ src/csr_sparse_store.sv @@
// response: an out-of-range word answers at once, its response valid the cycle after accept;
//   a get, a row-order error or a full store steps through S_RD_LO, S_RD_HI, S_SCAN_RD,
//   the column scan in S_SCAN_CMP and S_OUT; an overwrite and an insert add S_WRITE;
//   an insert also shifts entries up (S_SHIFT_RD, S_SHIFT_WR) or opens rows (S_SKIP)
// throughput: one word in flight; the next word is taken the cycle after its response
//   leaves, since every compare and every shift step needs one entry memory access
// reset: synchronous active-high; row-start memory cleared by a sweep over all
//   MAX_ROWS+1 entries after reset, during which no request word is accepted
`default_nettype none
module csr_sparse_store #(
   parameter int MAX_ROWS    = csr_pkg::DefMaxRows,
   parameter int MAX_COLUMNS = csr_pkg::DefMaxColumns,
   parameter int MAX_ENTRIES = csr_pkg::DefMaxEntries,
   parameter int VALUE_BITS  = csr_pkg::DefValueBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: func[0], row_index[10:1], column_index[20:11], write_value[84:21], zero pad
   input  wire logic [87:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: read_value[63:0], entry_found[64], entry_slot[76:65], status[78:77], pad
   output logic [79:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_we,
   input  wire logic [csr_pkg::CsrAddrBits-1:0] csr_index,
   input  wire logic [csr_pkg::CsrDataBits-1:0] csr_wdata
);
   import csr_pkg::*;

   localparam int RB = $clog2(MAX_ROWS + 1);      // row pointer index bits
   localparam int EB = $clog2(MAX_ENTRIES + 1);   // entry count bits
   localparam int AB = $clog2(MAX_ENTRIES);       // entry address bits
   localparam logic [RB-1:0] LAST_ROW = RB'(MAX_ROWS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_LO, S_RD_HI, S_SCAN_RD, S_SCAN_CMP,
      S_SKIP, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_OUT
   } state_type;

   // configuration registers
   logic [10:0] row_count_ff, col_count_ff;
   logic [12:0] capacity_ff;
   logic [63:0] absent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 11'd1024;
         col_count_ff <= 11'd1024;
         capacity_ff  <= 13'd4096;
         absent_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_ff <= csr_wdata[10:0];
            REG_COL_COUNT: col_count_ff <= csr_wdata[10:0];
            REG_CAPACITY:  capacity_ff  <= csr_wdata[12:0];
            REG_ABSENT:    absent_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memories
   logic [EB-1:0]         row_mem [MAX_ROWS+1];
   logic [IndexBits-1:0]  col_mem [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
   logic [EB-1:0]         row_rd_ff;
   logic [IndexBits-1:0]  col_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   logic                  row_we;
   logic [RB-1:0]         row_wa, row_ra;
   logic [EB-1:0]         row_wd;
   logic                  ent_we;
   logic [AB-1:0]         ent_wa, ent_ra;
   logic [IndexBits-1:0]  col_wd;
   logic [VALUE_BITS-1:0] val_wd;

   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      row_rd_ff <= row_mem[row_ra];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         col_mem[ent_wa] <= col_wd;
         val_mem[ent_wa] <= val_wd;
      end
      col_rd_ff <= col_mem[ent_ra];
      val_rd_ff <= val_mem[ent_ra];
   end

   // control state
   state_type state_ff;
   logic [RB-1:0]         clr_ff;
   logic                  func_ff;
   logic [IndexBits-1:0]  row_ff, colq_ff;
   logic [VALUE_BITS-1:0] wv_ff;
   logic [EB-1:0]         lo_ff, hi_ff, k_ff, z_ff, used_ff;
   logic [RB-1:0]         skip_ff;
   logic [IndexBits-1:0]  open_ff;
   logic                  rsp_valid_ff;
   logic [63:0]           rv_ff;
   logic                  found_ff;
   logic [SlotBits-1:0]   slot_ff;
   status_type            st_ff;

   logic [63:0] wv_in;
   logic        in_range;
   logic [16:0] row_lim, col_lim;
   logic [20:0] cap_lim;
   logic        req_fire;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign wv_in = req_tdata[84:21];

   always_comb begin
      row_lim = (17'(row_count_ff) < 17'(MAX_ROWS)) ? 17'(row_count_ff) : 17'(MAX_ROWS);
      col_lim = (17'(col_count_ff) < 17'(MAX_COLUMNS)) ? 17'(col_count_ff)
                                                         : 17'(MAX_COLUMNS);
      cap_lim = (21'(capacity_ff) < 21'(MAX_ENTRIES)) ? 21'(capacity_ff)
                                                       : 21'(MAX_ENTRIES);
      in_range = (17'(req_tdata[10:1]) < row_lim) && (17'(req_tdata[20:11]) < col_lim);
   end

   logic [EB-1:0] lo_c, hi_c;
   always_comb begin
      lo_c = lo_ff;
      hi_c = hi_ff;
      if (hi_c > used_ff) hi_c = used_ff;
      if (lo_c > hi_c) lo_c = hi_c;
   end

   // memory port drive
   always_comb begin
      row_we = 1'b0;
      row_wa = clr_ff;
      row_wd = used_ff;
      row_ra = RB'(row_ff);
      ent_we = 1'b0;
      ent_wa = AB'(z_ff);
      ent_ra = AB'(z_ff);
      col_wd = col_rd_ff;
      val_wd = val_rd_ff;
      case (state_ff)
         S_CLEAR: begin
            row_we = 1'b1;
            row_wd = '0;
         end
         S_IDLE:  row_ra = RB'(req_tdata[10:1]);
         S_RD_LO: row_ra = RB'(row_ff) + RB'(1);
         // first compare reads the row's first entry
         S_SCAN_RD: ent_ra = AB'(lo_c);
         // fetch the next entry while the current one is compared
         S_SCAN_CMP: ent_ra = AB'(z_ff + EB'(1));
         S_SKIP: begin
            row_we = 1'b1;
            row_wa = skip_ff;
         end
         S_SHIFT_RD: ent_ra = AB'(z_ff - EB'(1));
         S_SHIFT_WR: ent_we = 1'b1;
         S_WRITE: begin
            ent_we = 1'b1;
            ent_wa = AB'(k_ff);
            col_wd = colq_ff;
            val_wd = wv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         open_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + RB'(1);
               if (clr_ff == LAST_ROW) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire) begin
                  func_ff <= req_tdata[0];
                  row_ff  <= req_tdata[10:1];
                  colq_ff <= req_tdata[20:11];
                  wv_ff   <= VALUE_BITS'(wv_in);
                  if (!in_range) begin
                     rv_ff <= '0; found_ff <= 1'b0; slot_ff <= '0; st_ff <= ST_RANGE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_RD_LO;
                  end
               end
            end
            S_RD_LO: begin
               // row_rd_ff holds row_start[r]
               lo_ff <= row_rd_ff;
               state_ff <= S_RD_HI;
            end
            S_RD_HI: begin
               if (row_ff < open_ff) begin
                  hi_ff <= row_rd_ff;
               end else if (row_ff == open_ff) begin
                  hi_ff <= used_ff;
               end else begin
                  lo_ff <= used_ff;
                  hi_ff <= used_ff;
               end
               state_ff <= S_SCAN_RD;
               z_ff <= '0;
            end
            S_SCAN_RD: begin
               // first entry of the scan uses clamped bounds
               if (z_ff == '0) begin
                  lo_ff <= lo_c;
                  hi_ff <= hi_c;
                  z_ff  <= lo_c;
                  if (lo_c == hi_c) begin
                     k_ff <= hi_c;
                     found_ff <= 1'b0;
                     state_ff <= S_SCAN_CMP;
                  end else begin
                     state_ff <= S_SCAN_CMP;
                  end
               end
            end
            S_SCAN_CMP: begin
               // col_rd_ff holds entry_column[z] when z < hi
               if (z_ff < hi_ff && col_rd_ff < colq_ff) begin
                  z_ff <= z_ff + EB'(1);
                  if (z_ff + EB'(1) < hi_ff) begin
                     state_ff <= S_SCAN_CMP;  // read issued at address z + 1
                  end
               end else begin
                  logic hit;
                  hit = (z_ff < hi_ff) && (col_rd_ff == colq_ff);
                  k_ff <= z_ff;
                  if (func_ff == FUNC_GET) begin
                     rv_ff <= hit ? 64'(val_rd_ff) : 64'(VALUE_BITS'(absent_ff));
                     found_ff <= hit; slot_ff <= hit ? SlotBits'(z_ff) : '0;
                     st_ff <= ST_OK; state_ff <= S_OUT;
                  end else if (hit) begin
                     state_ff <= S_WRITE; found_ff <= 1'b1;
                  end else if (row_ff < open_ff) begin
                     rv_ff <= '0; found_ff <= 1'b0; slot_ff <= '0; st_ff <= ST_ORDER;
                     state_ff <= S_OUT;
                  end else if (21'(used_ff) >= cap_lim) begin
                     rv_ff <= '0; found_ff <= 1'b0; slot_ff <= '0; st_ff <= ST_FULL;
                     state_ff <= S_OUT;
                  end else begin
                     found_ff <= 1'b0;
                     if (row_ff > open_ff) begin
                        skip_ff <= RB'(open_ff) + RB'(1);
                        k_ff <= used_ff;
                        state_ff <= S_SKIP;
                     end else begin
                        z_ff <= used_ff;
                        state_ff <= (used_ff > z_ff) ? S_SHIFT_RD : S_WRITE;
                     end
                  end
               end
            end
            S_SKIP: begin
               skip_ff <= skip_ff + RB'(1);
               if (skip_ff == RB'(row_ff)) begin
                  open_ff <= row_ff;
                  state_ff <= S_WRITE;
               end
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               z_ff <= z_ff - EB'(1);
               state_ff <= (z_ff - EB'(1) > k_ff) ? S_SHIFT_RD : S_WRITE;
            end
            S_WRITE: begin
               rv_ff <= '0;
               slot_ff <= SlotBits'(k_ff);
               st_ff <= ST_OK;
               if (!found_ff) used_ff <= used_ff + EB'(1);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, st_ff, slot_ff, found_ff, rv_ff};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == S_IDLE) else $error("accept while busy");
   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      21'(used_ff) <= 21'(MAX_ENTRIES)) else $error("entry count overflow");
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && st_ff == ST_RANGE |-> rv_ff == '0 && !found_ff)
      else $error("range result not zero");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> $past(state_ff) == S_WRITE)
      else $error("entry count moved outside write");
`endif
endmodule
`default_nettype wire
